// File: rtl/imu_gravity_removal_yaw_bump_core_assert.svh
// Assertion macros for the gravity removal core.
`ifndef IMU_GRAVITY_REMOVAL_YAW_BUMP_CORE_ASSERT_SVH
`define IMU_GRAVITY_REMOVAL_YAW_BUMP_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define IGR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("igr assertion failed");
`define IGR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("igr assertion failed");
`else
`define IGR_ASSERT(lbl, clk, rst_n, prop)
`define IGR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/igr_pkg.sv
package igr_pkg;

    localparam int CORDIC_STAGES = 14;
    localparam int CNT_W         = $clog2(CORDIC_STAGES);
    localparam int CV_W          = 38;   // cordic x/y datapath
    localparam int ZW            = 20;   // angle accumulator, Q.16
    localparam int OPW           = 36;   // atan2 operand width
    localparam int HALF_PI_Q16   = 102944;
    localparam int PI_Q313       = 25736;

    localparam logic [11:0] GS_RESET  = 12'd2511;
    localparam logic [15:0] THR_RESET = 16'd1536;

    localparam logic ADDR_GS  = 1'b0;
    localparam logic ADDR_THR = 1'b1;

    function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] idx);
        logic [15:0] v;
        case (idx)
            5'd0:  v = 16'd51472;
            5'd1:  v = 16'd30386;
            5'd2:  v = 16'd16055;
            5'd3:  v = 16'd8150;
            5'd4:  v = 16'd4091;
            5'd5:  v = 16'd2047;
            5'd6:  v = 16'd1024;
            5'd7:  v = 16'd512;
            5'd8:  v = 16'd256;
            5'd9:  v = 16'd128;
            5'd10: v = 16'd64;
            5'd11: v = 16'd32;
            5'd12: v = 16'd16;
            5'd13: v = 16'd8;
            5'd14: v = 16'd4;
            5'd15: v = 16'd2;
            5'd16: v = 16'd1;
            default: v = 16'd0;
        endcase
        return signed'({{(ZW-16){1'b0}}, v});
    endfunction

endpackage

// File: rtl/igr_cordic.sv
module igr_cordic
    import igr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [OPW-1:0] i_x,
    input  logic signed [OPW-1:0] i_y,
    output logic                  o_done,
    output logic signed [15:0]    o_angle
);

    logic                  r_busy, r_done, r_zero;
    logic [CNT_W-1:0]      r_i;
    logic signed [CV_W-1:0] r_x, r_y;
    logic signed [ZW-1:0]  r_z;

    logic signed [CV_W-1:0] xe, ye, xs, ys;
    logic signed [ZW-1:0]   zr;

    assign xe = CV_W'(i_x);
    assign ye = CV_W'(i_y);
    // shared barrel shift, one step per cycle
    assign xs = r_x >>> r_i;
    assign ys = r_y >>> r_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_zero <= (i_x == '0) && (i_y == '0);
                if (i_x < 0) begin
                    if (i_y >= 0) begin
                        r_x <= ye;
                        r_y <= -xe;
                        r_z <= ZW'(HALF_PI_Q16);
                    end else begin
                        r_x <= -ye;
                        r_y <= xe;
                        r_z <= -ZW'(HALF_PI_Q16);
                    end
                end else begin
                    r_x <= xe;
                    r_y <= ye;
                    r_z <= '0;
                end
            end else if (r_busy) begin
                if (r_y >= 0) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + atan_q16(5'(r_i));
                end else begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - atan_q16(5'(r_i));
                end
                if (r_i == CNT_W'(CORDIC_STAGES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
        end
    end

    // round half up to Q3.13, clamp rounding excess past +/-pi
    assign zr = (r_z + ZW'(4)) >>> 3;

    always_comb begin
        if (r_zero) begin
            o_angle = '0;
        end else if (zr > ZW'(PI_Q313)) begin
            o_angle = 16'(PI_Q313);
        end else if (zr < -ZW'(PI_Q313)) begin
            o_angle = -16'(PI_Q313);
        end else begin
            o_angle = zr[15:0];
        end
    end

    assign o_done = r_done;

endmodule

// File: rtl/imu_gravity_removal_yaw_bump_core.sv
// Gravity removal, heading and bump detector for IMU samples. Each input word
// (quaternion Q1.14 plus raw acceleration) produces one output word with the
// gravity-free acceleration, the heading in Q3.13 radians and a bump flag.
// A sample runs from one accepted input word to the next through the accept
// cycle, 21 steps through one shared 36x17 multiply-accumulate unit,
// CORDIC_STAGES iterations of the vectoring CORDIC, a wait for the CORDIC to
// finish, then the output load. Input ready is high only while the sequencer is
// idle. A finished word waits in the output register while the next sample
// runs; if it has still not been taken when that sample finishes, the sequencer
// holds at the output load and input ready stays low.
// Registers: 0x0 gravity_scale (12 bit), 0x4 bump_threshold (16 bit).
module imu_gravity_removal_yaw_bump_core
    import igr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // quat_w, quat_x, quat_y, quat_z, accel_x_raw, accel_y_raw, accel_z_raw
    input  logic [111:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // yaw_angle, accel_right, accel_forward, accel_up, bump_forward, bump_up, pad
    output logic [103:0] o_m_axis_tdata,
    // bump_seen
    output logic [0:0]   o_m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

`include "imu_gravity_removal_yaw_bump_core_assert.svh"

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_CORD = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    localparam logic [4:0] ST_XZ   = 5'd0;
    localparam logic [4:0] ST_WY   = 5'd1;
    localparam logic [4:0] ST_G0   = 5'd2;
    localparam logic [4:0] ST_WX   = 5'd3;
    localparam logic [4:0] ST_YZ   = 5'd4;
    localparam logic [4:0] ST_G1   = 5'd5;
    localparam logic [4:0] ST_WW   = 5'd6;
    localparam logic [4:0] ST_XX   = 5'd7;
    localparam logic [4:0] ST_YY   = 5'd8;
    localparam logic [4:0] ST_ZZ   = 5'd9;
    localparam logic [4:0] ST_G2   = 5'd10;
    localparam logic [4:0] ST_SAT  = 5'd11;
    localparam logic [4:0] ST_DIFF = 5'd12;
    localparam logic [4:0] ST_DF2  = 5'd13;
    localparam logic [4:0] ST_DU2  = 5'd14;
    localparam logic [4:0] ST_THR  = 5'd15;
    localparam logic [4:0] ST_WZ   = 5'd16;
    localparam logic [4:0] ST_XY   = 5'd17;
    localparam logic [4:0] ST_YY2  = 5'd18;
    localparam logic [4:0] ST_ZZ2  = 5'd19;
    localparam logic [4:0] ST_CX   = 5'd20;

    logic [1:0]  r_state;
    logic [4:0]  r_step;
    logic [11:0] r_gs;
    logic [15:0] r_thr;

    logic signed [15:0] r_w, r_x, r_y, r_z, r_ax, r_ay, r_az;
    logic signed [OPW-1:0] r_acc, r_cy, r_cx;
    logic signed [17:0] r_g0, r_g1, r_g2;
    logic signed [15:0] r_ar, r_af, r_au, r_prev_f, r_prev_u;
    logic signed [16:0] r_df, r_du;
    logic               r_seen;

    logic         r_ovalid;
    logic [103:0] r_odata;
    logic         r_ouser;

    logic               cord_start, cord_done;
    logic signed [15:0] cord_angle;

    // shared multiply-accumulate unit
    logic signed [OPW-1:0] mul_a;
    logic signed [16:0]    mul_b;
    logic signed [52:0]    prod;
    logic signed [52:0]    rnd27, rnd28;
    logic signed [18:0]    dx, dy, dz;
    logic signed [15:0]    sat_x, sat_y, sat_z;
    logic                  s_acc, m_acc;

    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign m_acc = r_ovalid && i_m_axis_tready;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_step)
            ST_XZ:  begin mul_a = OPW'(r_x); mul_b = 17'(r_z); end
            ST_WY:  begin mul_a = OPW'(r_w); mul_b = 17'(r_y); end
            ST_WX:  begin mul_a = OPW'(r_w); mul_b = 17'(r_x); end
            ST_YZ:  begin mul_a = OPW'(r_y); mul_b = 17'(r_z); end
            ST_WW:  begin mul_a = OPW'(r_w); mul_b = 17'(r_w); end
            ST_XX:  begin mul_a = OPW'(r_x); mul_b = 17'(r_x); end
            ST_YY, ST_YY2: begin mul_a = OPW'(r_y); mul_b = 17'(r_y); end
            ST_ZZ, ST_ZZ2: begin mul_a = OPW'(r_z); mul_b = 17'(r_z); end
            ST_G0, ST_G1, ST_G2: begin
                mul_a = r_acc;
                mul_b = signed'({5'd0, r_gs});
            end
            ST_DF2: begin mul_a = OPW'(r_df); mul_b = r_df; end
            ST_DU2: begin mul_a = OPW'(r_du); mul_b = r_du; end
            ST_THR: begin
                mul_a = signed'({{(OPW-16){1'b0}}, r_thr});
                mul_b = signed'({1'b0, r_thr});
            end
            ST_WZ:  begin mul_a = OPW'(r_w); mul_b = 17'(r_z); end
            ST_XY:  begin mul_a = OPW'(r_x); mul_b = 17'(r_y); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign prod  = 53'(mul_a) * 53'(mul_b);
    assign rnd27 = (prod + (53'sd1 <<< 26)) >>> 27;
    assign rnd28 = (prod + (53'sd1 <<< 27)) >>> 28;

    assign dx = 19'(r_ax) - 19'(r_g0);
    assign dy = 19'(r_ay) - 19'(r_g1);
    assign dz = 19'(r_az) - 19'(r_g2);

    always_comb begin
        sat_x = (dx > 19'sd32767) ? 16'sh7fff : (dx < -19'sd32768) ? 16'sh8000 : dx[15:0];
        sat_y = (dy > 19'sd32767) ? 16'sh7fff : (dy < -19'sd32768) ? 16'sh8000 : dy[15:0];
        sat_z = (dz > 19'sd32767) ? 16'sh7fff : (dz < -19'sd32768) ? 16'sh8000 : dz[15:0];
    end

    assign cord_start = (r_state == S_RUN) && (r_step == ST_CX);

    igr_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_x     (r_cx),
        .i_y     (r_cy),
        .o_done  (cord_done),
        .o_angle (cord_angle)
    );

    // configuration port
    assign pready = 1'b1;
    always_comb begin
        case (paddr[2])
            ADDR_GS:  prdata = {20'd0, r_gs};
            ADDR_THR: prdata = {16'd0, r_thr};
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gs  <= GS_RESET;
            r_thr <= THR_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                ADDR_GS:  r_gs  <= pwdata[11:0];
                ADDR_THR: r_thr <= pwdata[15:0];
                default:  ;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= ST_XZ;
            r_prev_f <= '0;
            r_prev_u <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_w     <= i_s_axis_tdata[15:0];
                        r_x     <= i_s_axis_tdata[31:16];
                        r_y     <= i_s_axis_tdata[47:32];
                        r_z     <= i_s_axis_tdata[63:48];
                        r_ax    <= i_s_axis_tdata[79:64];
                        r_ay    <= i_s_axis_tdata[95:80];
                        r_az    <= i_s_axis_tdata[111:96];
                        r_step  <= ST_XZ;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_step <= r_step + 1'b1;
                    case (r_step)
                        ST_XZ, ST_WX, ST_WW, ST_DF2, ST_WZ: r_acc <= OPW'(prod);
                        ST_WY, ST_XX, ST_YY: r_acc <= r_acc - OPW'(prod);
                        ST_YZ, ST_ZZ, ST_DU2, ST_XY, ST_ZZ2: r_acc <= r_acc + OPW'(prod);
                        ST_G0: r_g0 <= rnd27[17:0];
                        ST_G1: r_g1 <= rnd27[17:0];
                        ST_G2: r_g2 <= rnd28[17:0];
                        ST_SAT: begin
                            r_ar <= sat_x;
                            r_af <= sat_y;
                            r_au <= sat_z;
                        end
                        ST_DIFF: begin
                            r_df     <= 17'(r_af) - 17'(r_prev_f);
                            r_du     <= 17'(r_au) - 17'(r_prev_u);
                            r_prev_f <= r_af;
                            r_prev_u <= r_au;
                        end
                        ST_THR: begin
                            r_seen <= r_acc > OPW'(prod);
                            if (!(r_acc > OPW'(prod))) begin
                                r_df <= '0;
                                r_du <= '0;
                            end
                        end
                        ST_YY2: begin
                            r_cy  <= r_acc <<< 1;
                            r_acc <= OPW'(prod);
                        end
                        ST_CX: begin
                            r_state <= S_CORD;
                        end
                        default: ;
                    endcase
                end
                S_CORD: begin
                    if (cord_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // cordic operand x = 1 - 2(y^2 + z^2), loaded one step before start
    always_ff @(posedge i_clk) begin
        if ((r_state == S_RUN) && (r_step == ST_ZZ2)) begin
            r_cx <= (OPW'(1) <<< 28) - ((r_acc + OPW'(prod)) <<< 1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((r_state == S_OUT) && (!r_ovalid || i_m_axis_tready)) begin
            r_ovalid <= 1'b1;
            r_odata  <= {6'd0, r_du, r_df, r_au, r_af, r_ar, cord_angle};
            r_ouser  <= r_seen;
        end else if (m_acc) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_m_axis_tvalid   = r_ovalid;
    assign o_m_axis_tdata    = r_odata;
    assign o_m_axis_tuser[0] = r_ouser;

    `IGR_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_acc, !o_s_axis_tready)
    `IGR_ASSERT(a_no_bump_zero, i_clk, i_rst_n,
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tdata[97:64] == '0))
    `IGR_ASSERT(a_yaw_range, i_clk, i_rst_n,
        o_m_axis_tvalid |-> ($signed(o_m_axis_tdata[15:0]) <= 16'sd25736 &&
                             $signed(o_m_axis_tdata[15:0]) >= -16'sd25736))

endmodule

// File: bench/imu_gravity_removal_yaw_bump_core_tb.sv
module imu_gravity_removal_yaw_bump_core_tb;
    import igr_pkg::*;

    typedef struct packed {
        logic signed [15:0] yaw;
        logic signed [15:0] right;
        logic signed [15:0] fwd;
        logic signed [15:0] up;
        logic               seen;
        logic signed [16:0] dfwd;
        logic signed [16:0] dup;
    } imu_result_t;

    localparam logic [2:0] REG_GS  = 3'd0;
    localparam logic [2:0] REG_THR = 3'd4;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [111:0] i_s_axis_tdata;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [103:0] o_m_axis_tdata;
    logic [0:0]   o_m_axis_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    imu_gravity_removal_yaw_bump_core DUT (.*);

    // model state
    longint      grav_scale;
    longint      bump_thr;
    longint      last_fwd;
    longint      last_up;
    imu_result_t expected_words[$];
    int          errors;
    int          src_idle_pct;
    int          snk_idle_pct;
    int          hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #300000000;
        $display("status: fail");
        $finish;
    end

    function automatic longint floor_shift(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint round_shift(longint v, int k);
        return (v + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    function automatic longint clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint heading(longint y, longint x);
        longint z;
        longint t;
        longint xs;
        longint ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = y; y = -x; x = t; z = HALF_PI_Q16;
            end else begin
                t = -y; y = x; x = t; z = -HALF_PI_Q16;
            end
        end
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y >= 0) begin
                x += ys; y -= xs; z += longint'(atan_q16(5'(i)));
            end else begin
                x -= ys; y += xs; z -= longint'(atan_q16(5'(i)));
            end
        end
        z = round_shift(z, 3);
        if (z > PI_Q313) z = PI_Q313;
        if (z < -PI_Q313) z = -PI_Q313;
        return z;
    endfunction

    function automatic imu_result_t compensate_sample(logic [111:0] d);
        longint w, x, y, z, ax, ay, az, t0, t1, t2, df, du;
        imu_result_t r;
        w  = longint'($signed(d[15:0]));
        x  = longint'($signed(d[31:16]));
        y  = longint'($signed(d[47:32]));
        z  = longint'($signed(d[63:48]));
        ax = longint'($signed(d[79:64]));
        ay = longint'($signed(d[95:80]));
        az = longint'($signed(d[111:96]));
        t0 = round_shift((x * z - w * y) * grav_scale, 27);
        t1 = round_shift((w * x + y * z) * grav_scale, 27);
        t2 = round_shift((w * w - x * x - y * y + z * z) * grav_scale, 28);
        r.right = 16'(clip16(ax - t0));
        r.fwd   = 16'(clip16(ay - t1));
        r.up    = 16'(clip16(az - t2));
        r.yaw   = 16'(heading(2 * (w * z + x * y), (longint'(1) <<< 28) - 2 * (y * y + z * z)));
        df = longint'(r.fwd) - last_fwd;
        du = longint'(r.up) - last_up;
        r.seen = (df * df + du * du) > bump_thr * bump_thr;
        r.dfwd = r.seen ? 17'(df) : 17'd0;
        r.dup  = r.seen ? 17'(du) : 17'd0;
        last_fwd = longint'(r.fwd);
        last_up  = longint'(r.up);
        return r;
    endfunction

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= addr; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == REG_GS) grav_scale = longint'(value[11:0]);
        else if (addr == REG_THR) bump_thr = longint'(value[15:0]);
        @(posedge i_clk);
    endtask

    task automatic send_sample(input logic [111:0] d);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= d;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        expected_words.push_back(compensate_sample(d));
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        i_s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (60) @(posedge i_clk);
    endtask

    function automatic logic [111:0] pack_sample(int w, int x, int y, int z,
                                                 int ax, int ay, int az);
        return {16'(az), 16'(ay), 16'(ax), 16'(z), 16'(y), 16'(x), 16'(w)};
    endfunction

    function automatic int rand_s16();
        return int'($signed(16'($urandom)));
    endfunction

    function automatic logic [111:0] rand_unit_sample();
        int c[4];
        int acc;
        foreach (c[k]) c[k] = int'($urandom_range(16384)) - 8192;
        // rough normalization keeps quaternion near unit length
        acc = 0;
        foreach (c[k]) acc += (c[k] * c[k]) >>> 14;
        if (acc > 0)
            foreach (c[k]) c[k] = (c[k] * 16384) / (acc < 4096 ? 8192 : 16384);
        foreach (c[k]) if (c[k] > 16384) c[k] = 16384; else if (c[k] < -16384) c[k] = -16384;
        return pack_sample(c[0], c[1], c[2], c[3],
                           int'($urandom_range(4000)) - 2000 + (($urandom_range(19) == 0) ? rand_s16() : 0),
                           int'($urandom_range(4000)) - 2000,
                           int'($urandom_range(6000)) - 500);
    endfunction

    // check each output word against the oldest prediction
    always @(posedge i_clk) begin
        imu_result_t got;
        imu_result_t exp_r;
        if (i_rst_n) begin
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.yaw   = o_m_axis_tdata[15:0];
                got.right = o_m_axis_tdata[31:16];
                got.fwd   = o_m_axis_tdata[47:32];
                got.up    = o_m_axis_tdata[63:48];
                got.dfwd  = o_m_axis_tdata[80:64];
                got.dup   = o_m_axis_tdata[97:81];
                got.seen  = o_m_axis_tuser[0];
                if (expected_words.size() == 0) begin
                    $error("unexpected output word");
                    errors++;
                end else begin
                    exp_r = expected_words.pop_front();
                    if (got.yaw !== exp_r.yaw) begin
                        $error("yaw_angle exp %0d got %0d", exp_r.yaw, got.yaw); errors++;
                    end
                    if (got.right !== exp_r.right) begin
                        $error("accel_right exp %0d got %0d", exp_r.right, got.right); errors++;
                    end
                    if (got.fwd !== exp_r.fwd) begin
                        $error("accel_forward exp %0d got %0d", exp_r.fwd, got.fwd); errors++;
                    end
                    if (got.up !== exp_r.up) begin
                        $error("accel_up exp %0d got %0d", exp_r.up, got.up); errors++;
                    end
                    if (got.seen !== exp_r.seen) begin
                        $error("bump_seen exp %0d got %0d", exp_r.seen, got.seen); errors++;
                    end
                    if (got.dfwd !== exp_r.dfwd) begin
                        $error("bump_forward exp %0d got %0d", exp_r.dfwd, got.dfwd); errors++;
                    end
                    if (got.dup !== exp_r.dup) begin
                        $error("bump_up exp %0d got %0d", exp_r.dup, got.dup); errors++;
                    end
                end
            end
        end
    end

    task automatic test_directed;
        send_sample(pack_sample(16384, 0, 0, 0, 0, 0, 0));
        send_sample(pack_sample(16384, 0, 0, 0, 32767, 32767, 32767));
        send_sample(pack_sample(16384, 0, 0, 0, -32768, -32768, -32768));
        send_sample(pack_sample(0, 0, 0, 0, 0, 0, 0));          // zero quaternion, atan2 y operand zero
        send_sample(pack_sample(0, 0, 0, 16384, 100, -100, 0)); // yaw at pi
        send_sample(pack_sample(0, 0, 0, -16384, 0, 0, 0));
        send_sample(pack_sample(11585, 0, 0, 11585, 0, 0, 0));
        send_sample(pack_sample(11585, 0, 0, -11585, 0, 0, 0));
        send_sample(pack_sample(5000, 0, 0, 15000, 0, 0, 0));   // negative real operand
        send_sample(pack_sample(5000, 0, 0, -15000, 0, 0, 0));
        send_sample(pack_sample(-16384, -16384, -16384, -16384, 0, 0, 0));
        send_sample(pack_sample(16384, 16384, 16384, 16384, 0, 0, 0));
        send_sample(pack_sample(-32768, -32768, 32767, 32767, 1, 2, 3)); // out of range
        send_sample(pack_sample(32767, -32768, -32768, 32767, -5, 5, -5));
        send_sample(pack_sample(0, 16384, 0, 0, 0, 0, 0));
        send_sample(pack_sample(0, 0, 16384, 0, 0, 0, 0));
        send_sample(pack_sample(16384, 0, 0, 0, 0, 0, 1000));   // small raw step, gravity change still flags a bump
        send_sample(pack_sample(16384, 0, 0, 0, 0, 0, 30000));  // large step
        drain();
    endtask

    task automatic test_registers;
        reg_write(REG_GS, 32'hFFFF_F000);   // upper bits dropped, zero gravity
        reg_write(REG_THR, 32'd0);
        for (int n = 0; n < 8; n++) send_sample(rand_unit_sample());
        drain();
        reg_write(REG_GS, 32'd4095);
        reg_write(REG_THR, 32'hFFFF);
        for (int n = 0; n < 8; n++) send_sample(pack_sample(rand_s16(), rand_s16(), rand_s16(),
                                                            rand_s16(), rand_s16(), rand_s16(),
                                                            rand_s16()));
        drain();
        reg_write(REG_GS, 32'd2511);
        reg_write(REG_THR, 32'd1536);
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(9) == 0)
                send_sample(pack_sample(rand_s16(), rand_s16(), rand_s16(), rand_s16(),
                                        rand_s16(), rand_s16(), rand_s16()));
            else
                send_sample(rand_unit_sample());
        end
        drain();
    endtask

    task automatic test_backpressure;
        hold_cycles = 400;
        for (int n = 0; n < 10; n++) send_sample(rand_unit_sample());
        drain();
    endtask

    initial begin
        errors = 0;
        grav_scale = longint'(GS_RESET);
        bump_thr   = longint'(THR_RESET);
        last_fwd = 0;
        last_up  = 0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_cycles  = 0;
        i_rst_n <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_m_axis_tready <= 1'b0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        paddr <= '0; pwdata <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_registers();
        src_idle_pct = 6; snk_idle_pct = 84;
        test_random(330);
        reg_write(REG_GS, 32'd0);
        reg_write(REG_THR, 32'd200);
        src_idle_pct = 84; snk_idle_pct = 6;
        test_random(330);
        reg_write(REG_GS, 32'd2511);
        reg_write(REG_THR, 32'd1536);
        src_idle_pct = 0; snk_idle_pct = 0;
        test_random(330);
        test_backpressure();
        if (errors == 0 && expected_words.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
